FILE: rtl/tuiu_pkg.sv
// Shared types, constants and character helpers for the text-to-integer converter.
`timescale 1ns / 1ps

package tuiu_pkg;

  // Longest string position tracked before the counter saturates
  localparam longint unsigned MAX_STRING_LENGTH_DEF = 64'd65535;

  // Field widths
  localparam int VALUE_W  = 64;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int BASE_W   = 6;
  localparam int CHAR_W   = 8;
  localparam int DIGIT_W  = 7;
  localparam int PHASE_W  = 3;

  // Largest end offset that can be reported
  localparam logic [OFFSET_W-1:0] END_OFFSET_MAX = '1;

  // Radix limits and defaults
  localparam logic [BASE_W-1:0] BASE_AUTO    = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE     = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT     = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC     = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX     = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX     = 6'd36;
  localparam logic [BASE_W-1:0] BASE_MIN     = 6'd2;
  localparam logic [BASE_W-1:0] BASE_RST     = BASE_DEC;

  // Parse phases
  localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SIGNED = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ZERO   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  // Digit value that no radix accepts
  localparam logic [DIGIT_W-1:0] DIGIT_NONE = 7'd99;

  // Per-string parse state
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [VALUE_W-1:0] acc;
    logic               minus;
    logic [BASE_W-1:0]  base;
    logic               ovf;
    logic               invalid;
  } parse_state_t;

  // One result
  typedef struct packed {
    logic [VALUE_W-1:0]  value;
    logic [OFFSET_W-1:0] end_offset;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Digit value of a character, letters in either case from 10 up
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    begin
      d = CH_NUL;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        d = c - CH_LA + 8'd10;
      end else if (c >= CH_UA && c <= CH_UZ) begin
        d = c - CH_UA + 8'd10;
      end else begin
        d = {1'b0, DIGIT_NONE};
      end
      digit_of = d[DIGIT_W-1:0];
    end
  endfunction

  // Whitespace: space, tab, LF, VT, FF, CR
  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

endpackage

FILE: rtl/text_to_unsigned_integer_top.sv
// Top level of the streaming text-to-unsigned-integer converter.
`timescale 1ns / 1ps
//
//  channel     | signals                               | direction
//  ------------+---------------------------------------+----------
//  characters  | char_valid, char_stall, char_code     | in
//  results     | result_valid, result_stall, value,    | out
//              | end_offset, status                    |
//  radix reg   | number_base_we, number_base           | in
//
//  One byte per cycle is taken while char_stall is low: a byte is registered,
//  then decode and radix multiply-add update the parse state.
//  A zero byte in the input register loads its result into the output register.
//  rst clears the parse state, both valid flags and sets the radix to 10.
//  A held result only stalls the character side when a zero byte is ready
//  behind it; other bytes keep flowing.

module text_to_unsigned_integer_top
  import tuiu_pkg::*;
#(
  parameter longint unsigned MAX_STRING_LENGTH = MAX_STRING_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                number_base_we,
  input  logic [BASE_W-1:0]   number_base,
  input  logic                char_valid,
  output logic                char_stall,
  input  logic [CHAR_W-1:0]   char_code,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [VALUE_W-1:0]  value,
  output logic [OFFSET_W-1:0] end_offset,
  output logic [STATUS_W-1:0] status
);

  localparam int POS_W  = $clog2(MAX_STRING_LENGTH + 64'd1);
  localparam int STOP_W = $clog2(MAX_STRING_LENGTH + 64'd2);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_STRING_LENGTH);

  logic [BASE_W-1:0] base_reg;
  logic [CHAR_W-1:0] char_r;
  logic              char_full;
  parse_state_t      st;
  parse_state_t      st_next;
  logic [POS_W-1:0]  position;
  logic [STOP_W-1:0] stop_pos;
  logic [STOP_W-1:0] stop_next;
  result_t           res_next;
  result_t           res;
  logic              is_term;
  logic              proc_go;

  // Radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= BASE_RST;
    end else if (number_base_we) begin
      base_reg <= number_base;
    end
  end

  // A byte is processed unless it is a terminator blocked by a held result
  assign is_term    = (char_r == CH_NUL);
  assign proc_go    = char_full && (!is_term || !result_valid || !result_stall);
  assign char_stall = char_full && !proc_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_full <= 1'b0;
    end else if (char_valid && !char_stall) begin
      char_full <= 1'b1;
    end else if (proc_go) begin
      char_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      char_r <= char_code;
    end
  end

  tuiu_step #(
    .POS_W  (POS_W),
    .STOP_W (STOP_W)
  ) u_step (
    .char_in   (char_r),
    .cfg_base  (base_reg),
    .st        (st),
    .position  (position),
    .stop_pos  (stop_pos),
    .st_next   (st_next),
    .stop_next (stop_next),
    .result    (res_next)
  );

  // Parse state: cleared after every terminator
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= '{phase: PH_SPACE, default: '0};
      position <= '0;
      stop_pos <= '0;
    end else if (proc_go) begin
      if (is_term) begin
        st       <= '{phase: PH_SPACE, default: '0};
        position <= '0;
        stop_pos <= '0;
      end else begin
        st       <= st_next;
        stop_pos <= stop_next;
        if (position < POS_MAX) begin
          position <= position + POS_W'(1);
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_go && is_term) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && is_term) begin
      res <= res_next;
    end
  end

  assign value      = res.value;
  assign end_offset = res.end_offset;
  assign status     = res.status;

endmodule

FILE: rtl/tuiu_step.sv
// Next-state and result logic for one character of the string.
`timescale 1ns / 1ps

module tuiu_step
  import tuiu_pkg::*;
#(
  parameter int POS_W  = 16,
  parameter int STOP_W = 17
) (
  input  logic [CHAR_W-1:0] char_in,
  input  logic [BASE_W-1:0] cfg_base,
  input  parse_state_t      st,
  input  logic [POS_W-1:0]  position,
  input  logic [STOP_W-1:0] stop_pos,
  output parse_state_t      st_next,
  output logic [STOP_W-1:0] stop_next,
  output result_t           result
);

  localparam int XW   = STOP_W + OFFSET_W;
  localparam int PR_W = VALUE_W + BASE_W + 1;

  logic              first;
  logic              bad_base;
  logic [BASE_W-1:0] base_eff;
  logic [PHASE_W-1:0] phase_eff;
  logic              inv_eff;
  logic [DIGIT_W-1:0] dig;
  logic              want_take;
  logic              fail_done;
  logic [BASE_W-1:0] tb;
  logic              take_ok;
  logic [PR_W-1:0]   sum;
  logic [STOP_W-1:0] pos_inc;
  logic [XW-1:0]     stop_wide;
  logic              res_invalid;

  // Radix latched on the first byte of each string
  assign first     = (position == '0);
  assign bad_base  = (cfg_base == BASE_ONE) || (cfg_base > BASE_MAX);
  assign base_eff  = first ? cfg_base : st.base;
  assign phase_eff = (first && bad_base) ? PH_DONE : st.phase;
  assign inv_eff   = st.invalid | (first && bad_base);
  assign dig       = digit_of(char_in);
  assign pos_inc   = STOP_W'(position) + STOP_W'(1);

  // Phase decode: pick the action and the radix used for a digit
  always_comb begin
    st_next         = st;
    st_next.phase   = phase_eff;
    st_next.base    = base_eff;
    st_next.invalid = inv_eff;
    stop_next       = stop_pos;
    want_take       = 1'b0;
    fail_done       = 1'b0;
    tb              = base_eff;
    unique case (phase_eff)
      PH_SPACE, PH_SIGNED: begin
        if (phase_eff == PH_SPACE && is_space(char_in)) begin
          st_next.phase = PH_SPACE;
        end else if (phase_eff == PH_SPACE &&
                     (char_in == CH_PLUS || char_in == CH_MINUS)) begin
          st_next.minus = (char_in == CH_MINUS);
          st_next.phase = PH_SIGNED;
        end else if (base_eff == BASE_AUTO) begin
          // auto radix: first character must be a decimal digit
          if (char_in < CH_0 || char_in > CH_9) begin
            st_next.invalid = 1'b1;
            st_next.phase   = PH_DONE;
          end else if (char_in == CH_0) begin
            stop_next     = pos_inc;
            st_next.phase = PH_ZERO;
          end else begin
            st_next.base = BASE_DEC;
            tb           = BASE_DEC;
            want_take    = 1'b1;
          end
        end else if (base_eff == BASE_HEX && char_in == CH_0) begin
          stop_next     = pos_inc;
          st_next.phase = PH_ZERO;
        end else begin
          want_take = 1'b1;
          fail_done = 1'b1;
        end
      end
      PH_ZERO: begin
        if (char_in == CH_LX || char_in == CH_UX) begin
          st_next.base  = BASE_HEX;
          st_next.phase = PH_PREFIX;
        end else begin
          tb           = (base_eff == BASE_AUTO) ? BASE_OCT : base_eff;
          st_next.base = tb;
          want_take    = 1'b1;
          fail_done    = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        want_take = 1'b1;
        fail_done = 1'b1;
      end
      default: begin
        st_next.phase = phase_eff;
      end
    endcase

    // Multiply-add by the active radix
    take_ok = (tb >= BASE_MIN) && (dig < DIGIT_W'(tb));
    sum     = PR_W'(st.acc) * PR_W'(tb) + PR_W'(dig);

    // Digit accumulate with exact overflow detection
    if (want_take) begin
      if (take_ok) begin
        if (!st.ovf) begin
          if (sum[PR_W-1:VALUE_W] != '0) begin
            st_next.ovf = 1'b1;
            st_next.acc = '1;
          end else begin
            st_next.acc = sum[VALUE_W-1:0];
          end
        end
        stop_next     = pos_inc;
        st_next.phase = PH_DIGITS;
      end else if (fail_done) begin
        st_next.phase = PH_DONE;
      end
    end
  end

  // Result when this character is the terminator
  assign res_invalid = inv_eff || (phase_eff == PH_SPACE) ||
                       (phase_eff == PH_SIGNED && base_eff == BASE_AUTO);
  assign stop_wide   = XW'(stop_pos);

  always_comb begin
    result = '0;
    if (res_invalid) begin
      result.status = ST_INVALID;
    end else begin
      if (st.ovf) begin
        result.value  = '1;
        result.status = ST_RANGE;
      end else begin
        result.value  = st.minus ? (VALUE_W'(0) - st.acc) : st.acc;
        result.status = ST_OK;
      end
      result.end_offset = (stop_wide > XW'(END_OFFSET_MAX)) ? END_OFFSET_MAX :
                          stop_wide[OFFSET_W-1:0];
    end
  end

endmodule
